/* sv/wedge_region_pixel_mask_defines.svh */
// assertion macros for the wedge region pixel mask
// expects i_clk and i_rst_n in the scope of each use
`ifndef WEDGE_REGION_PIXEL_MASK_DEFINES_SVH
`define WEDGE_REGION_PIXEL_MASK_DEFINES_SVH

// same-cycle implication, off during reset
`define WRPM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define WRPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wrpm_pkg.sv */
// shared widths, defaults and register codes for the wedge region pixel mask
// no dependencies
`default_nettype none

package wrpm_pkg;

    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int IDX_W     = 19;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_BITS = 16;

    // busy count loaded on a register write; pixel intake waits for it to run out
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOPE_FIRST      = 2'd0,
        CFG_INTERCEPT_FIRST  = 2'd1,
        CFG_SLOPE_SECOND     = 2'd2,
        CFG_INTERCEPT_SECOND = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

/* sv/wrpm_ifs.sv */
// valid/ready channels of the wedge region pixel mask: pixel in, result out, config write
// depends on wrpm_pkg
`default_nettype none

interface wrpm_pix_if import wrpm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;

    modport source (output valid, column, row, input ready);
    modport sink   (input valid, column, row, output ready);
endinterface

interface wrpm_res_if import wrpm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [IDX_W-1:0] pixel_index;

    modport source (output valid, inside_res, pixel_index, input ready);
    modport sink   (input valid, inside_res, pixel_index, output ready);
endinterface

interface wrpm_cfg_if import wrpm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/wedge_region_pixel_mask.sv */
// top level of the wedge region pixel mask: config registers, horizon terms, pixel pipeline
// depends on wrpm_pkg, wrpm_ifs and wedge_region_pixel_mask_defines.svh
`default_nettype none
`include "wedge_region_pixel_mask_defines.svh"

// Flags each raster pixel as inside or outside the floor wedge bounded by two
// lines row = slope*col + intercept (Q16.16 registers). The block takes one
// pixel beat per clock unless the result path or the horizon settle holds it
// off, and passes each pixel through the input register and then the result
// register, with the per-pixel multiplies and exact compares in between. A
// stalled result does not stop intake while the input register is free. After
// each config write the pixel input holds ready low while the horizon terms
// (two 32x32 products, their difference and the height bound) are recomputed;
// config writes are meant for idle periods only. pixel_index is
// row*IMAGE_WIDTH+column wrapped to 19 bits.
module wedge_region_pixel_mask import wrpm_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    wrpm_cfg_if.sink   i_cfg,
    wrpm_pix_if.sink   i_pix,
    wrpm_res_if.source o_res
);

    // derived widths
    localparam int PQ_W   = 2 * CFG_W;                         // slope x intercept
    localparam int DS_W   = CFG_W + 1;                         // slope difference
    localparam int E_W    = PQ_W + 1;                          // signed horizon numerator
    localparam int HL_W   = $clog2(IMAGE_HEIGHT + 1) + DS_W;   // height times |ds|
    localparam int RA_W   = ROW_W + DS_W;                      // row times |ds|
    localparam int CMP_W  = (HL_W + FRAC_BITS + 1 > E_W + 1) ?
                            (HL_W + FRAC_BITS + 1) : (E_W + 1);
    localparam int MUL_W  = COL_W + 1 + CFG_W;                 // column times slope
    localparam int T_W    = MUL_W + 2;                         // side-of-line term
    localparam int IX_P_W = ROW_W + $clog2(IMAGE_WIDTH + 1) + 1;
    localparam int IX_W   = (IX_P_W > IDX_W) ? IX_P_W : IDX_W;

    // handshakes
    logic cfg_fire;
    logic pix_fire;
    logic adv_in;
    logic adv_out;

    // config registers
    logic signed [CFG_W-1:0] r_s1;
    logic signed [CFG_W-1:0] r_b1;
    logic signed [CFG_W-1:0] r_s2;
    logic signed [CFG_W-1:0] r_b2;

    // horizon terms, rebuilt after every write
    logic [1:0]              r_busy;
    logic signed [PQ_W-1:0]  r_p;
    logic signed [PQ_W-1:0]  r_q;
    logic signed [DS_W-1:0]  r_ds;
    logic signed [E_W-1:0]   r_e;
    logic [DS_W-1:0]         r_ads;
    logic [HL_W-1:0]         r_hlim;
    logic                    r_limited;

    logic signed [PQ_W-1:0]  n_p;
    logic signed [PQ_W-1:0]  n_q;
    logic signed [DS_W-1:0]  n_ds;
    logic signed [E_W-1:0]   n_diff;
    logic                    n_neg;
    logic signed [E_W-1:0]   n_e;
    logic [DS_W-1:0]         n_ads;
    logic [HL_W-1:0]         n_hlim;
    logic signed [CMP_W-1:0] hlim_sh;
    logic                    n_limited;

    // pixel pipeline
    logic             r_in_valid;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_out_valid;
    logic             r_inside;
    logic [IDX_W-1:0] r_index;

    logic signed [MUL_W-1:0] m1;
    logic signed [MUL_W-1:0] m2;
    logic signed [T_W-1:0]   row_t;
    logic signed [T_W-1:0]   t1;
    logic signed [T_W-1:0]   t2;
    logic [RA_W-1:0]         row_ads;
    logic signed [CMP_W-1:0] row_lim;
    logic                    below;
    logic                    n_inside;
    logic [IX_W-1:0]         idx_full;
    logic [IDX_W-1:0]        n_index;

    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign pix_fire    = i_pix.valid && i_pix.ready;
    assign adv_out     = !r_out_valid || o_res.ready;
    assign adv_in      = !r_in_valid || adv_out;

    // config always taken; pixels held off while horizon terms settle
    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = adv_in && (r_busy == 2'd0);

    assign o_res.valid       = r_out_valid;
    assign o_res.inside_res  = r_inside;
    assign o_res.pixel_index = r_index;

    // ---------------------------------------------------------------
    // config register file
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_b1 <= '0;
            r_s2 <= '0;
            r_b2 <= '0;
        end else if (cfg_fire) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_SLOPE_FIRST:      r_s1 <= i_cfg.data;
                CFG_INTERCEPT_FIRST:  r_b1 <= i_cfg.data;
                CFG_SLOPE_SECOND:     r_s2 <= i_cfg.data;
                CFG_INTERCEPT_SECOND: r_b2 <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // horizon terms: three register steps after the config registers
    //   step 1: p = s1*b2, q = s2*b1, ds = s1-s2
    //   step 2: e = sign(ds)*(p-q), |ds|, height*|ds|
    //   step 3: horizon strictly inside the image (0 < e < H*|ds|*2^16)
    // ---------------------------------------------------------------
    always_comb begin
        n_p    = PQ_W'(r_s1) * PQ_W'(r_b2);
        n_q    = PQ_W'(r_s2) * PQ_W'(r_b1);
        n_ds   = DS_W'(r_s1) - DS_W'(r_s2);

        n_diff = E_W'(r_p) - E_W'(r_q);
        n_neg  = r_ds[DS_W-1];
        n_e    = n_neg ? -n_diff : n_diff;
        n_ads  = n_neg ? DS_W'(-r_ds) : DS_W'(r_ds);
        n_hlim = HL_W'(n_ads) * HL_W'(IMAGE_HEIGHT);

        // height bound in the same Q.16 scale as e
        hlim_sh   = $signed(CMP_W'({r_hlim, {FRAC_BITS{1'b0}}}));
        n_limited = (r_ads != '0) && (r_e > 0) && (CMP_W'(r_e) < hlim_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 2'd0;
            r_p       <= '0;
            r_q       <= '0;
            r_ds      <= '0;
            r_e       <= '0;
            r_ads     <= '0;
            r_hlim    <= '0;
            r_limited <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_busy <= CFG_SETTLE;
            end else if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
            r_p       <= n_p;
            r_q       <= n_q;
            r_ds      <= n_ds;
            r_e       <= n_e;
            r_ads     <= n_ads;
            r_hlim    <= n_hlim;
            r_limited <= n_limited;
        end
    end

    // ---------------------------------------------------------------
    // per-pixel test between input register and result register
    // ---------------------------------------------------------------
    always_comb begin
        // signed distance of the pixel from each line along the column axis:
        // t = col*s + b - row*2^16, its sign times sign(s) gives the side
        m1    = MUL_W'($signed({1'b0, r_col})) * MUL_W'(r_s1);
        m2    = MUL_W'($signed({1'b0, r_col})) * MUL_W'(r_s2);
        row_t = $signed(T_W'({r_row, {FRAC_BITS{1'b0}}}));
        t1    = T_W'(m1) + T_W'(r_b1) - row_t;
        t2    = T_W'(m2) + T_W'(r_b2) - row_t;

        // row below the horizon: e < row*|ds|*2^16 when the horizon is inside the image, else any nonzero row
        row_ads = RA_W'(r_row) * RA_W'(r_ads);
        row_lim = $signed(CMP_W'({row_ads, {FRAC_BITS{1'b0}}}));
        below   = r_limited ? (CMP_W'(r_e) < row_lim) : (r_row != '0);

        // strictly between the lines: both sides nonzero and opposite
        n_inside = below && (r_s1 != '0) && (r_s2 != '0) &&
                   (t1 != '0) && (t2 != '0) &&
                   ((t1[T_W-1] ^ r_s1[CFG_W-1]) != (t2[T_W-1] ^ r_s2[CFG_W-1]));

        idx_full = IX_W'(r_row) * IX_W'(IMAGE_WIDTH) + IX_W'(r_col);
        n_index  = idx_full[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= pix_fire;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_col <= i_pix.column;
            r_row <= i_pix.row;
        end
        if (adv_out && r_in_valid) begin
            r_inside <= n_inside;
            r_index  <= n_index;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `WRPM_ASSERT_NEXT(a_cfg_blocks_pixels, cfg_fire, !i_pix.ready, "pixel taken before settle")
    `WRPM_ASSERT_NEXT(a_pixel_captured, pix_fire, r_in_valid, "accepted pixel beat dropped")
    `WRPM_ASSERT_NEXT(a_pixel_to_result, r_in_valid && adv_out, r_out_valid,
                      "pixel did not reach result register")
    `WRPM_ASSERT_IMPL(a_limit_needs_gap, r_limited, $past(r_ads) != '0,
                      "horizon limit with equal slopes")

endmodule

`default_nettype wire
